// ----- rtl/core/ile_pkg.sv -----
// Package for the indexed list engine: field widths, request codes, control structs.
`default_nettype none
package ile_pkg;

    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 3'd0,
        MODE_HEAD   = 3'd1,
        MODE_TAIL   = 3'd2,
        MODE_INSERT = 3'd3,
        MODE_DELETE = 3'd4
    } t_mode;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture a new request
        logic step;    // one tick of the shift walk
        logic fetch;   // read the addressed entry
        logic fill;    // write the new value into its slot
        logic finish;  // commit length and publish the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic new_ok;     // incoming request is in range, and for an insert the list is not full
        logic new_read;   // incoming request is a read
        logic ins;        // latched request is an insert
        logic walk_done;  // no shift reads left to issue
    } t_stat;

endpackage
`default_nettype wire

// ----- rtl/core/ile_ctrl.sv -----
// Sequencer for the indexed list engine: one-hot state machine driving the datapath.
`default_nettype none
module ile_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire ile_pkg::t_stat i_stat,
    output ile_pkg::t_cmd      o_cmd,
    output logic               busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_FILL  = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.new_ok) begin
                        n_state = S_DONE;
                    end else if (i_stat.new_read) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = i_stat.ins ? S_FILL : S_DONE;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_DONE;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/core/ile_datapath.sv -----
// Datapath for the indexed list engine: element memory, shift walk, length and result registers.
`default_nettype none
module ile_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ile_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [ile_pkg::POS_W-1:0]   i_position,
    input  wire logic signed [ile_pkg::VAL_W-1:0] i_value,
    input  wire ile_pkg::t_cmd               i_cmd,
    output ile_pkg::t_stat                   o_stat,
    output logic signed [ile_pkg::VAL_W-1:0] o_read_value,
    output logic                             o_read_hit,
    output logic                             o_accepted,
    output logic [ile_pkg::LEN_W-1:0]        o_list_length,
    output logic                             o_valid
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

    // Element store
    logic [ile_pkg::VAL_W-1:0] r_mem [CAPACITY];
    logic [ile_pkg::VAL_W-1:0] r_rd_data;

    // Request and walk registers
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_left;
    logic                      r_wr_pend;
    logic                      r_ok;
    logic                      r_is_read;
    logic                      r_is_ins;
    logic [CW-1:0]             r_tpos;
    logic [ile_pkg::VAL_W-1:0] r_value;
    logic [AW-1:0]             r_rd_addr;
    logic [AW-1:0]             r_wr_addr;

    // Result registers
    logic                      r_valid;
    logic                      r_hit;
    logic                      r_acc;
    logic [ile_pkg::VAL_W-1:0] r_rvalue;

    // Decode of the incoming request
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] tpos_x;
    logic          full;
    logic          new_ok;
    logic          new_read;
    logic          new_ins;
    logic          new_del;
    logic [CW-1:0] n_tpos;
    logic [CW-1:0] n_left;
    logic [AW-1:0] n_rd_addr;
    logic [AW-1:0] n_wr_addr;

    always_comb begin
        pos_x    = XW'(i_position);
        cnt_x    = XW'(r_count);
        full     = (r_count == CW'(CAPACITY));
        new_ok   = 1'b0;
        new_read = 1'b0;
        new_ins  = 1'b0;
        new_del  = 1'b0;
        tpos_x   = pos_x;
        case (ile_pkg::t_mode'(i_mode))
            ile_pkg::MODE_READ: begin
                new_read = 1'b1;
                new_ok   = (pos_x < cnt_x);
            end
            ile_pkg::MODE_HEAD: begin
                new_ins = 1'b1;
                tpos_x  = '0;
                new_ok  = !full;
            end
            ile_pkg::MODE_TAIL: begin
                new_ins = 1'b1;
                tpos_x  = cnt_x;
                new_ok  = !full;
            end
            ile_pkg::MODE_INSERT: begin
                new_ins = 1'b1;
                new_ok  = !full && (pos_x <= cnt_x);
            end
            ile_pkg::MODE_DELETE: begin
                new_del = 1'b1;
                new_ok  = (pos_x < cnt_x);
            end
            default: begin
                new_ok = 1'b0;
            end
        endcase
        n_tpos = CW'(tpos_x);
        // insert walks down from the tail, delete walks up from the gap
        if (new_ok && new_ins) begin
            n_left    = r_count - n_tpos;
            n_rd_addr = AW'(r_count - CW'(1));
            n_wr_addr = AW'(r_count);
        end else if (new_ok && new_del) begin
            n_left    = r_count - n_tpos - CW'(1);
            n_rd_addr = AW'(n_tpos + CW'(1));
            n_wr_addr = AW'(n_tpos);
        end else begin
            n_left    = '0;
            n_rd_addr = '0;
            n_wr_addr = '0;
        end
    end

    // Memory port control: one read and one write per cycle
    logic                      issue;
    logic                      mem_re;
    logic                      mem_we;
    logic [AW-1:0]             ra;
    logic [AW-1:0]             wa;
    logic [ile_pkg::VAL_W-1:0] wd;

    assign issue  = i_cmd.step && (r_left != '0);
    assign mem_re = issue || i_cmd.fetch;
    assign mem_we = (i_cmd.step && r_wr_pend) || i_cmd.fill;
    assign ra     = i_cmd.fetch ? r_tpos[AW-1:0] : r_rd_addr;
    assign wa     = i_cmd.fill ? r_tpos[AW-1:0] : r_wr_addr;
    assign wd     = i_cmd.fill ? r_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wa] <= wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_wr_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_left    <= n_left;
                r_wr_pend <= 1'b0;
            end else if (i_cmd.step) begin
                r_wr_pend <= issue;
                if (issue) begin
                    r_left <= r_left - CW'(1);
                end
            end
            if (i_cmd.finish && r_ok) begin
                if (r_is_ins) begin
                    r_count <= r_count + CW'(1);
                end else if (!r_is_read) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
    end

    // Request capture, walk addresses and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok      <= new_ok;
            r_is_read <= new_read;
            r_is_ins  <= new_ins;
            r_tpos    <= n_tpos;
            r_value   <= i_value;
            r_rd_addr <= n_rd_addr;
            r_wr_addr <= n_wr_addr;
        end
        if (issue) begin
            r_rd_addr <= r_is_ins ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
        end
        if (i_cmd.step && r_wr_pend) begin
            r_wr_addr <= r_is_ins ? (r_wr_addr - AW'(1)) : (r_wr_addr + AW'(1));
        end
        if (i_cmd.finish) begin
            r_hit    <= r_is_read && r_ok;
            r_acc    <= r_ok;
            r_rvalue <= (r_is_read && r_ok) ? r_rd_data : '1;
        end
    end

    assign o_stat.new_ok    = new_ok;
    assign o_stat.new_read  = new_read;
    assign o_stat.ins       = r_is_ins;
    assign o_stat.walk_done = (r_left == '0);

    assign o_valid       = r_valid;
    assign o_read_hit    = r_hit;
    assign o_accepted    = r_acc;
    assign o_read_value  = r_rvalue;
    assign o_list_length = cnt_x[ile_pkg::LEN_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/core/indexed_list_engine.sv -----
// Top level of the indexed list engine: position-addressed list of signed 32-bit values.
//
// Requests come in on start/busy: a beat is taken at a clock edge with start high
// and busy low (i_mode, i_position, i_value). Every request gives exactly one
// result beat, shown for one cycle with o_valid: o_read_value, o_read_hit,
// o_accepted and o_list_length. The receiver cannot hold a result off.
// After the accepting edge, a read fetches the addressed entry; an insert shifts
// the entries from the position P up by one, walking down from the tail, then
// writes the new value into the gap; a delete shifts the entries above P down by
// one, walking up from the gap; a rejected or unknown request goes straight to
// the done state. Each then publishes its result with o_valid.
// busy is low again in the o_valid cycle, so the next request can be taken then;
// a new request is not taken while the last one is in flight. The time a request
// takes is set by the shift walk: one read and one write of the single element
// memory a cycle.
// Reset clears the length to zero; the memory is not cleared, and entries at or
// beyond the length are never read.
`default_nettype none
module indexed_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [ile_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [ile_pkg::POS_W-1:0]        i_position,
    input  wire logic signed [ile_pkg::VAL_W-1:0] i_value,
    output logic                                  o_valid,
    output logic signed [ile_pkg::VAL_W-1:0]      o_read_value,
    output logic                                  o_read_hit,
    output logic                                  o_accepted,
    output logic [ile_pkg::LEN_W-1:0]             o_list_length
);

    ile_pkg::t_cmd  cmd;
    ile_pkg::t_stat stat;

    ile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ile_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_read_value  (o_read_value),
        .o_read_hit    (o_read_hit),
        .o_accepted    (o_accepted),
        .o_list_length (o_list_length),
        .o_valid       (o_valid)
    );

endmodule
`default_nettype wire

// ----- rtl/core/ile_checker.sv -----
// Port-level checker for the indexed list engine, bound to the top level.
`default_nettype none
module ile_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             o_valid,
    input wire logic signed [ile_pkg::VAL_W-1:0] o_read_value,
    input wire logic                             o_read_hit,
    input wire logic                             o_accepted
);

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request beat taken without going busy");

    // Result beat lasts one cycle and shows with the block free
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy ##1 !o_valid)
        else $error("result beat longer than one cycle or shown while busy");

    // Finishing a request always publishes its result
    a_fell_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("request finished with no result beat");

    // A read hit is an accepted request
    a_hit_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_hit |-> o_accepted)
        else $error("read hit not flagged accepted");

    // Anything but a read hit returns all ones
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_read_hit |-> (o_read_value == -32'sd1))
        else $error("read value not -1 without a hit");

endmodule

bind indexed_list_engine ile_checker u_chk (.*);
`default_nettype wire
